// ===== hdl/pjq_pkg.sv =====
// Package with shared constants for the priority job queue.
`timescale 1ns / 1ps
`default_nettype none
package pjq_pkg;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF = 32;
    localparam int LEVELS = 3;
    localparam logic [7:0] FAIR_RESET = 8'd4;

    localparam logic [1:0] REQ_SUBMIT = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_TAKE = 2'd2;
    localparam logic [1:0] REQ_SHUTDOWN = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_STOPPED = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;
endpackage
`default_nettype wire

// ===== hdl/priority_job_queue_with_fairness_core.sv =====
// Top level of the priority job queue with a starvation counter.
//
//  Port group     Direction  Handshake
//  request        in         i_start, o_busy (accepted when start and not busy)
//  result         out        o_done strobe, one cycle, no back-pressure
//  configuration  in         i_cfg_we, i_cfg_data (fairness interval)
//
// Submit, take and shutdown pass through the read, take and done states from
// accept to result; the queue memory read is registered. When not stopped,
// cancel scans the queues one slot per cycle and then shifts the tail of its
// queue down one slot at a time through a read and a write state. Reset is
// synchronous, clears the queue pointers and the stop flag and sets the id
// counter to one; the memory is not cleared. The result cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module priority_job_queue_with_fairness_core #(
    parameter int QUEUE_DEPTH = pjq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS = pjq_pkg::ID_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  [1:0]  i_req_type,
    input  wire  [1:0]  i_priority_req,
    input  wire  [31:0] i_job_id,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_data,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [31:0] o_out_job_id,
    output logic [1:0]  o_out_priority,
    output logic [5:0]  o_queued_total,
    output logic [5:0]  o_cleared_count
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int MD = pjq_pkg::LEVELS * QUEUE_DEPTH;
    localparam int AW = $clog2(MD);
    localparam int TW = $clog2(MD + 1);
    localparam int CW = (ID_BITS < 32) ? ID_BITS : 32;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_TAKE = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_SHRD = 3'd4;
    localparam logic [2:0] S_SHWR = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [ID_BITS-1:0] r_mem [MD];
    logic [ID_BITS-1:0] r_rdata;
    logic [AW-1:0] n_raddr;
    logic n_we;
    logic [AW-1:0] n_waddr;
    logic [ID_BITS-1:0] n_wdata;

    logic [2:0] r_state, n_state;
    logic [PW-1:0] r_head [pjq_pkg::LEVELS];
    logic [FW-1:0] r_fill [pjq_pkg::LEVELS];
    logic [ID_BITS-1:0] r_next_id;
    logic [7:0] r_skip, r_fair;
    logic r_stopped;
    logic [1:0] r_req, r_lvl;
    logic [ID_BITS-1:0] r_want;
    logic [FW-1:0] r_pos;
    logic r_done;
    logic [2:0] r_status;
    logic [31:0] r_oid;
    logic [1:0] r_oprio;
    logic [5:0] r_cleared;

    logic [TW-1:0] w_total;
    assign w_total = TW'(r_fill[0]) + TW'(r_fill[1]) + TW'(r_fill[2]);

    function automatic logic [AW-1:0] slot(input logic [1:0] l,
                                           input logic [PW-1:0] h,
                                           input logic [FW-1:0] p);
        logic [FW:0] s;
        s = (FW+1)'(h) + (FW+1)'(p);
        if (s >= (FW+1)'(QUEUE_DEPTH)) s = s - (FW+1)'(QUEUE_DEPTH);
        return AW'(l) * AW'(QUEUE_DEPTH) + AW'(s);
    endfunction

    logic [1:0] w_lvl_in;
    assign w_lvl_in = (i_priority_req == 2'd3) ? 2'd2 : i_priority_req;

    // Take selection from fill levels and the starvation counter.
    logic w_any, w_lower, w_fair;
    logic [1:0] w_top, w_low, w_pick;
    always_comb begin
        w_any = (r_fill[0] != '0) || (r_fill[1] != '0) || (r_fill[2] != '0);
        w_top = (r_fill[0] != '0) ? 2'd0 : ((r_fill[1] != '0) ? 2'd1 : 2'd2);
        w_lower = 1'b0;
        w_low = 2'd2;
        if (w_top == 2'd0) begin
            w_lower = (r_fill[1] != '0) || (r_fill[2] != '0);
            w_low = (r_fill[1] != '0) ? 2'd1 : 2'd2;
        end else if (w_top == 2'd1) begin
            w_lower = (r_fill[2] != '0);
        end
        w_fair = w_lower && (r_skip >= r_fair);
        w_pick = w_fair ? w_low : w_top;
    end

    logic [FW-1:0] w_fill_l;
    logic [PW-1:0] w_head_l;
    assign w_fill_l = r_fill[r_lvl];
    assign w_head_l = r_head[r_lvl];

    always_comb begin
        n_state = r_state;
        n_raddr = slot(r_lvl, w_head_l, r_pos);
        n_we = 1'b0;
        n_waddr = slot(r_lvl, w_head_l, r_pos);
        n_wdata = r_rdata;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (r_stopped || i_req_type != pjq_pkg::REQ_CANCEL)
                        n_state = S_READ;
                    else
                        n_state = S_SCAN;
                end
            end
            S_READ: n_state = S_TAKE;
            S_TAKE: n_state = S_DONE;
            S_SCAN: begin
                if (r_pos != '0 && r_rdata == r_want) begin
                    if (r_pos >= w_fill_l) n_state = S_DONE;
                    else n_state = S_SHRD;
                end else if (r_pos >= w_fill_l && r_lvl == 2'd2) begin
                    n_state = S_DONE;
                end
            end
            S_SHRD: n_state = S_SHWR;
            S_SHWR: begin
                n_we = 1'b1;
                n_waddr = slot(r_lvl, w_head_l, r_pos - FW'(1));
                if (r_pos + FW'(1) >= w_fill_l) n_state = S_DONE;
                else n_state = S_SHRD;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_IDLE)
            n_raddr = slot(w_pick, r_head[w_pick], '0);
        if (r_state == S_READ && r_req == pjq_pkg::REQ_SUBMIT && !r_stopped
            && w_fill_l < FW'(QUEUE_DEPTH)) begin
            n_we = 1'b1;
            n_waddr = slot(r_lvl, w_head_l, w_fill_l);
            n_wdata = r_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_waddr] <= n_wdata;
        r_rdata <= r_mem[n_raddr];
    end

    logic [31:0] w_id32, w_rd32, w_want32;
    always_comb begin
        w_id32 = '0;
        w_rd32 = '0;
        w_want32 = '0;
        w_id32[CW-1:0] = r_next_id[CW-1:0];
        w_rd32[CW-1:0] = r_rdata[CW-1:0];
        w_want32[CW-1:0] = r_want[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int l = 0; l < pjq_pkg::LEVELS; l++) begin
                r_head[l] <= '0;
                r_fill[l] <= '0;
            end
            r_next_id <= ID_BITS'(1);
            r_skip <= '0;
            r_fair <= pjq_pkg::FAIR_RESET;
            r_stopped <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done <= 1'b0;
            if (i_cfg_we) r_fair <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    r_req <= i_req_type;
                    r_lvl <= (i_req_type == pjq_pkg::REQ_CANCEL) ? 2'd0 :
                             ((i_req_type == pjq_pkg::REQ_TAKE) ? w_pick : w_lvl_in);
                    r_want <= ID_BITS'(i_job_id);
                    r_pos <= '0;
                    r_oid <= '0;
                    r_oprio <= '0;
                    r_cleared <= '0;
                    r_status <= pjq_pkg::ST_OK;
                end
                S_READ: begin
                    if (r_stopped) begin
                        r_status <= pjq_pkg::ST_STOPPED;
                    end else if (r_req == pjq_pkg::REQ_SUBMIT) begin
                        if (w_fill_l >= FW'(QUEUE_DEPTH)) begin
                            r_status <= pjq_pkg::ST_FULL;
                        end else begin
                            r_fill[r_lvl] <= w_fill_l + FW'(1);
                            r_oid <= w_id32;
                            r_next_id <= r_next_id + ID_BITS'(1);
                        end
                    end else if (r_req == pjq_pkg::REQ_SHUTDOWN) begin
                        r_cleared <= 6'(w_total);
                        for (int l = 0; l < pjq_pkg::LEVELS; l++) begin
                            r_head[l] <= '0;
                            r_fill[l] <= '0;
                        end
                        r_stopped <= 1'b1;
                    end else if (!w_any) begin
                        r_status <= pjq_pkg::ST_EMPTY;
                    end else begin
                        if (w_fair) r_skip <= '0;
                        else if (w_lower) begin
                            if (r_skip != 8'hFF) r_skip <= r_skip + 8'd1;
                        end else r_skip <= '0;
                        r_oprio <= r_lvl;
                        r_oid <= w_rd32;
                        r_head[r_lvl] <= (w_head_l == PW'(QUEUE_DEPTH - 1)) ? '0 :
                                         w_head_l + PW'(1);
                        r_fill[r_lvl] <= w_fill_l - FW'(1);
                    end
                end
                S_TAKE: ;
                S_SCAN: begin
                    // r_pos addresses the slot read last cycle plus one.
                    if (r_pos != '0 && r_rdata == r_want) begin
                        r_oid <= w_want32;
                        r_oprio <= r_lvl;
                        if (r_pos >= w_fill_l)
                            r_fill[r_lvl] <= w_fill_l - FW'(1);
                    end else if (r_pos >= w_fill_l) begin
                        if (r_lvl == 2'd2) begin
                            r_status <= pjq_pkg::ST_NOT_FOUND;
                        end else begin
                            r_lvl <= r_lvl + 2'd1;
                            r_pos <= '0;
                        end
                    end else begin
                        r_pos <= r_pos + FW'(1);
                    end
                end
                S_SHRD: ;
                S_SHWR: begin
                    r_pos <= r_pos + FW'(1);
                    if (r_pos + FW'(1) >= w_fill_l)
                        r_fill[r_lvl] <= w_fill_l - FW'(1);
                end
                S_DONE: r_done <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_status = r_status;
    assign o_out_job_id = r_oid;
    assign o_out_priority = r_oprio;
    assign o_queued_total = 6'(w_total);
    assign o_cleared_count = r_cleared;

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[0] <= FW'(QUEUE_DEPTH) && r_fill[1] <= FW'(QUEUE_DEPTH)
        && r_fill[2] <= FW'(QUEUE_DEPTH)) else $error("queue overfilled");
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped) else $error("stop flag dropped");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE) else $error("result while busy");
    a_stopped_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stopped && r_state == S_IDLE) |-> w_total == '0)
        else $error("queued jobs after shutdown");
endmodule
`default_nettype wire
